>>> hdl/avr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the axis vector rotation pipeline.
// No dependencies; imported by every module under hdl/.
package avr_pkg;

    localparam int CS_W   = 33;
    localparam int TURN_W = 32;

    localparam logic [1:0] MODE_X    = 2'd0;
    localparam logic [1:0] MODE_Y    = 2'd1;
    localparam logic [1:0] MODE_Z    = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    // 0.60725293 * 2^30, CORDIC limit gain
    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    // atan(2^-i) in 32-bit binary turns, rounded to nearest
    localparam logic [TURN_W-1:0] ATAN_TURN32 [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [CS_W-1:0] z;
    } cordic_state_t;

endpackage

>>> hdl/avr_angle_fold.sv
`timescale 1ns / 1ps
// Input stage: folds the angle into a quadrant and a residual, seeds the CORDIC.
// Depends on avr_pkg.
module avr_angle_fold #(
    parameter int ANGLE_BITS = 16,
    parameter int SIDE_W     = 98
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ANGLE_BITS-1:0] angle,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output avr_pkg::cordic_state_t out_state,
    output logic [1:0]            out_quad,
    output logic [SIDE_W-1:0]     out_side
);
    import avr_pkg::*;

    logic                vld_reg;
    cordic_state_t       state_reg, state_next;
    logic [1:0]          quad_reg, quad_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [TURN_W-1:0]   a32;
    logic [TURN_W-1:0]   a32_bias;
    logic [TURN_W-1:0]   resid;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        a32        = {angle, {(TURN_W - ANGLE_BITS){1'b0}}};
        a32_bias   = a32 + 32'h2000_0000;
        quad_next  = a32_bias[TURN_W-1:TURN_W-2];
        resid      = a32 - {quad_next, {(TURN_W - 2){1'b0}}};
        state_next.x = CORDIC_GAIN_Q30;
        state_next.y = '0;
        state_next.z = $signed({resid[TURN_W-1], resid});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            quad_reg  <= quad_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = vld_reg;
    assign out_state = state_reg;
    assign out_quad  = quad_reg;
    assign out_side  = side_reg;

endmodule

>>> hdl/avr_cordic_stage.sv
`timescale 1ns / 1ps
// One registered CORDIC rotation-mode micro-rotation.
// Depends on avr_pkg.
module avr_cordic_stage #(
    parameter int STAGE_IDX = 0,
    parameter int SIDE_W    = 100
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  avr_pkg::cordic_state_t in_state,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    input  logic                   out_ready,
    output avr_pkg::cordic_state_t out_state,
    output logic [SIDE_W-1:0]      out_side
);
    import avr_pkg::*;

    localparam int K = STAGE_IDX % 32;

    logic                   vld_reg;
    cordic_state_t          state_reg, state_next;
    logic [SIDE_W-1:0]      side_reg;
    logic signed [CS_W-1:0] dx;
    logic signed [CS_W-1:0] dy;
    logic signed [CS_W-1:0] atan_k;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        dx     = in_state.y >>> K;
        dy     = in_state.x >>> K;
        atan_k = $signed({1'b0, ATAN_TURN32[K]});
        if (!in_state.z[CS_W-1])
        begin
            state_next.x = in_state.x - dx;
            state_next.y = in_state.y + dy;
            state_next.z = in_state.z - atan_k;
        end
        else
        begin
            state_next.x = in_state.x + dx;
            state_next.y = in_state.y - dy;
            state_next.z = in_state.z + atan_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = vld_reg;
    assign out_state = state_reg;
    assign out_side  = side_reg;

endmodule

>>> hdl/avr_rotate.sv
`timescale 1ns / 1ps
// Back end: quadrant unfold and trig rounding, products, rounded sums, clipping.
// Four register stages; depends on avr_pkg.
module avr_rotate #(
    parameter int COORD_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  avr_pkg::cordic_state_t in_state,
    input  logic [1:0]             in_quad,
    input  logic [1:0]             in_mode,
    input  logic [COORD_BITS-1:0]  in_x,
    input  logic [COORD_BITS-1:0]  in_y,
    input  logic [COORD_BITS-1:0]  in_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  x_out,
    output logic [COORD_BITS-1:0]  y_out,
    output logic [COORD_BITS-1:0]  z_out,
    output logic                   saturated
);
    import avr_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int TRIG_FRAC = ((62 - C) < 30) ? (62 - C) : 30;
    localparam int SH        = 30 - TRIG_FRAC;
    localparam int TW        = CS_W - SH;
    localparam int PW        = C + TW;
    localparam int RW        = PW + 1 - TRIG_FRAC;

    localparam logic signed [CS_W-1:0] TRIG_RND = CS_W'((64'd1 << SH) >> 1);
    localparam logic signed [PW:0]     FIN_RND  = (PW + 1)'(1) << (TRIG_FRAC - 1);
    localparam logic signed [RW-1:0]   SAT_HI   = {{(RW - C + 1){1'b0}}, {(C - 1){1'b1}}};
    localparam logic signed [RW-1:0]   SAT_LO   = {{(RW - C + 1){1'b1}}, {(C - 1){1'b0}}};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: trig
    logic signed [CS_W-1:0] c_fold, s_fold, c_sum, s_sum, c_shr, s_shr;
    logic signed [TW-1:0]   c_reg, c_next, s_reg, s_next;
    logic [1:0]             mode1_reg;
    logic [C-1:0]           x1_reg, y1_reg, z1_reg;

    // stage 2: products
    logic signed [C-1:0]    p_sel, q_sel;
    logic signed [PW-1:0]   pc_reg, pc_next, qs_reg, qs_next;
    logic signed [PW-1:0]   ps_reg, ps_next, qc_reg, qc_next;
    logic [1:0]             mode2_reg;
    logic [C-1:0]           x2_reg, y2_reg, z2_reg;

    // stage 3: rounded sums
    logic signed [PW:0]     sum_a, sum_b, shr_a, shr_b;
    logic signed [RW-1:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic [1:0]             mode3_reg;
    logic [C-1:0]           x3_reg, y3_reg, z3_reg;

    // stage 4: clip and place
    logic [C-1:0]           pa_clip, qb_clip;
    logic                   sat_a, sat_b;
    logic [C-1:0]           xo_reg, xo_next, yo_reg, yo_next, zo_reg, zo_next;
    logic                   sat_reg, sat_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_comb
    begin
        case (in_quad)
            2'd0:
            begin
                c_fold = in_state.x;
                s_fold = in_state.y;
            end
            2'd1:
            begin
                c_fold = -in_state.y;
                s_fold = in_state.x;
            end
            2'd2:
            begin
                c_fold = -in_state.x;
                s_fold = -in_state.y;
            end
            default:
            begin
                c_fold = in_state.y;
                s_fold = -in_state.x;
            end
        endcase
        c_sum  = c_fold + TRIG_RND;
        s_sum  = s_fold + TRIG_RND;
        c_shr  = c_sum >>> SH;
        s_shr  = s_sum >>> SH;
        c_next = c_shr[TW-1:0];
        s_next = s_shr[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            mode1_reg <= in_mode;
            x1_reg    <= in_x;
            y1_reg    <= in_y;
            z1_reg    <= in_z;
        end
    end

    always_comb
    begin
        case (mode1_reg)
            MODE_X:
            begin
                p_sel = y1_reg;
                q_sel = z1_reg;
            end
            MODE_Y:
            begin
                p_sel = x1_reg;
                q_sel = z1_reg;
            end
            default:
            begin
                p_sel = x1_reg;
                q_sel = y1_reg;
            end
        endcase
        pc_next = PW'(p_sel) * PW'(c_reg);
        qs_next = PW'(q_sel) * PW'(s_reg);
        ps_next = PW'(p_sel) * PW'(s_reg);
        qc_next = PW'(q_sel) * PW'(c_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            pc_reg    <= pc_next;
            qs_reg    <= qs_next;
            ps_reg    <= ps_next;
            qc_reg    <= qc_next;
            mode2_reg <= mode1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
        end
    end

    always_comb
    begin
        sum_a   = (PW + 1)'(pc_reg) - (PW + 1)'(qs_reg) + FIN_RND;
        sum_b   = (PW + 1)'(ps_reg) + (PW + 1)'(qc_reg) + FIN_RND;
        shr_a   = sum_a >>> TRIG_FRAC;
        shr_b   = sum_b >>> TRIG_FRAC;
        ra_next = shr_a[RW-1:0];
        rb_next = shr_b[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            ra_reg    <= ra_next;
            rb_reg    <= rb_next;
            mode3_reg <= mode2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
        end
    end

    always_comb
    begin
        sat_a   = 1'b0;
        sat_b   = 1'b0;
        pa_clip = ra_reg[C-1:0];
        qb_clip = rb_reg[C-1:0];
        if (ra_reg > SAT_HI)
        begin
            sat_a   = 1'b1;
            pa_clip = SAT_HI[C-1:0];
        end
        else if (ra_reg < SAT_LO)
        begin
            sat_a   = 1'b1;
            pa_clip = SAT_LO[C-1:0];
        end
        if (rb_reg > SAT_HI)
        begin
            sat_b   = 1'b1;
            qb_clip = SAT_HI[C-1:0];
        end
        else if (rb_reg < SAT_LO)
        begin
            sat_b   = 1'b1;
            qb_clip = SAT_LO[C-1:0];
        end
        xo_next  = x3_reg;
        yo_next  = y3_reg;
        zo_next  = z3_reg;
        sat_next = sat_a || sat_b;
        case (mode3_reg)
            MODE_X:
            begin
                yo_next = pa_clip;
                zo_next = qb_clip;
            end
            MODE_Y:
            begin
                xo_next = pa_clip;
                zo_next = qb_clip;
            end
            MODE_Z:
            begin
                xo_next = pa_clip;
                yo_next = qb_clip;
            end
            default:
            begin
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            xo_reg  <= xo_next;
            yo_reg  <= yo_next;
            zo_reg  <= zo_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v4_reg;
    assign x_out     = xo_reg;
    assign y_out     = yo_reg;
    assign z_out     = zo_reg;
    assign saturated = sat_reg;

endmodule

>>> hdl/axis_vector_rotation.sv
`timescale 1ns / 1ps
// Top level: stream ports, angle fold, CORDIC stage chain, rotate back end.
// Depends on avr_pkg, avr_angle_fold, avr_cordic_stage, avr_rotate.
//
// Rotates a Q16.16 vector about the x, y or z axis (tuser mode 0/1/2; mode 3
// passes the vector through) by a binary angle, 2^ANGLE_BITS per turn. Fully
// pipelined: one beat per cycle in and out while the sink is ready, through
// one angle fold stage, one stage per CORDIC iteration, and four back-end
// stages (trig rounding, multiply, rounded sum, clip). Every stage holds its
// beat under back-pressure and fills bubbles, so input is taken while results
// wait at the output, as long as some stage is empty. Clipped results raise
// the saturated flag in m_axis_tuser.
module axis_vector_rotation #(
    parameter int COORD_BITS    = 32,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    localparam int IN_W  = ((3 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // x_in, y_in, z_in, turn_angle
    input  logic [1:0]       s_axis_tuser,   // mode
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // x_out, y_out, z_out
    output logic [0:0]       m_axis_tuser    // saturated
);
    import avr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int SIDE_W = 2 + 3 * C;
    localparam int CH_W   = SIDE_W + 2;
    localparam logic [C-1:0] COORD_HI = {1'b0, {(C - 1){1'b1}}};
    localparam logic [C-1:0] COORD_LO = {1'b1, {(C - 1){1'b0}}};

    logic [SIDE_W-1:0]  in_side;
    logic               fold_valid, fold_ready;
    cordic_state_t      fold_state;
    logic [1:0]         fold_quad;
    logic [SIDE_W-1:0]  fold_side;

    logic               ch_valid [CORDIC_STAGES+1];
    logic               ch_ready [CORDIC_STAGES+1];
    cordic_state_t      ch_state [CORDIC_STAGES+1];
    logic [CH_W-1:0]    ch_side  [CORDIC_STAGES+1];

    logic [CH_W-1:0]    tail_side;
    logic [C-1:0]       x_res, y_res, z_res;
    logic               sat_res;

    assign in_side = {s_axis_tuser, s_axis_tdata[2*C +: C], s_axis_tdata[C +: C],
                      s_axis_tdata[0 +: C]};

    avr_angle_fold #(
        .ANGLE_BITS (ANGLE_BITS),
        .SIDE_W     (SIDE_W)
    ) u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .angle     (s_axis_tdata[3*C +: ANGLE_BITS]),
        .in_side   (in_side),
        .out_valid (fold_valid),
        .out_ready (fold_ready),
        .out_state (fold_state),
        .out_quad  (fold_quad),
        .out_side  (fold_side)
    );

    assign ch_valid[0] = fold_valid;
    assign fold_ready  = ch_ready[0];
    assign ch_state[0] = fold_state;
    assign ch_side[0]  = {fold_quad, fold_side};

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        avr_cordic_stage #(
            .STAGE_IDX (i),
            .SIDE_W    (CH_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_state  (ch_state[i]),
            .in_side   (ch_side[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_state (ch_state[i+1]),
            .out_side  (ch_side[i+1])
        );
    end

    assign tail_side = ch_side[CORDIC_STAGES];

    avr_rotate #(
        .COORD_BITS (C)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ch_valid[CORDIC_STAGES]),
        .in_ready  (ch_ready[CORDIC_STAGES]),
        .in_state  (ch_state[CORDIC_STAGES]),
        .in_quad   (tail_side[CH_W-1 -: 2]),
        .in_mode   (tail_side[3*C +: 2]),
        .in_x      (tail_side[0 +: C]),
        .in_y      (tail_side[C +: C]),
        .in_z      (tail_side[2*C +: C]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .x_out     (x_res),
        .y_out     (y_res),
        .z_out     (z_res),
        .saturated (sat_res)
    );

    assign m_axis_tdata = OUT_W'({z_res, y_res, x_res});
    assign m_axis_tuser = sat_res;

    // a ready sink never back-pressures the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output sink is ready");

    // a clipped beat carries at least one coordinate at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (x_res == COORD_HI || x_res == COORD_LO ||
             y_res == COORD_HI || y_res == COORD_LO ||
             z_res == COORD_HI || z_res == COORD_LO))
        else $error("saturated flag without a clipped coordinate");

    // with an idle input and the input side ready, the fold stage is empty in the next cycle
    a_fold_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tvalid && s_axis_tready) |=> !fold_valid)
        else $error("fold stage kept a beat that was never accepted");

endmodule
